// ===== src/uhb_pkg.sv =====
// Shared types, constants and register codes for the UDP/IPv4 header builder.
package uhb_pkg;

  // Frame size limit and header geometry.
  localparam int MAX_FRAME_BYTES = 4096;
  localparam int HDR_BYTES       = 42;
  localparam int HDR_WORDS       = 21;
  localparam logic [4:0] LAST_INDEX = 5'(HDR_WORDS - 1);

  // Fixed header contents.
  localparam logic [15:0] ETH_TYPE_IPV4  = 16'h0800;
  localparam logic [15:0] IP_VER_IHL_TOS = 16'h4500;
  localparam logic [15:0] IP_TTL_PROTO   = {8'd100, 8'd17};
  localparam logic [15:0] IP_LEN_EXTRA   = 16'd28;
  localparam logic [15:0] UDP_LEN_EXTRA  = 16'd8;

  // Checksum accumulator width: ten 16-bit words need at most 20 bits.
  localparam int CSUM_W     = 20;
  localparam int CFG_CSUM_W = 18;

  // Register reset values.
  localparam logic [31:0] LOCAL_IP_RESET  = 32'h0A00_020F;
  localparam logic [47:0] LOCAL_MAC_RESET = 48'h5254_0012_3456;
  localparam logic [47:0] PEER_MAC_RESET  = 48'h5255_0A00_0202;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_LOCAL_IP  = 2'd0;
  localparam logic [1:0] REG_LOCAL_MAC = 2'd1;
  localparam logic [1:0] REG_PEER_MAC  = 2'd2;

  // Header word positions that need special handling.
  localparam logic [4:0] POS_IP_CSUM = 5'd12;

  // Send request word.
  typedef struct packed {
    logic [15:0] src_port;
    logic [31:0] dst_ip_addr;
    logic [15:0] dst_port;
    logic [15:0] payload_bytes;
  } req_t;

  // Header result word.
  typedef struct packed {
    logic [15:0] header_word;
    logic [4:0]  word_index;
    logic        last_word;
    logic        rejected;
  } hdr_t;

  // Classified job handed from the front part to the back part.
  typedef struct packed {
    logic              rejected;
    logic [15:0]       src_port;
    logic [31:0]       dst_ip_addr;
    logic [15:0]       dst_port;
    logic [15:0]       ip_len;
    logic [15:0]       udp_len;
    logic [CSUM_W-1:0] csum_sum;
  } job_t;

endpackage

// ===== src/uhb_front.sv =====
// Front part: size check, length fields and the raw IPv4 checksum sum.
module uhb_front
  import uhb_pkg::*;
(
  input  req_t                  req,
  input  logic [CFG_CSUM_W-1:0] cfg_sum,
  output job_t                  job
);

  logic [16:0] frame_bytes;

  // Reject anything whose full frame would exceed the limit.
  assign frame_bytes = {1'b0, req.payload_bytes} + 17'(HDR_BYTES);

  always_comb begin
    job.rejected    = frame_bytes > 17'(MAX_FRAME_BYTES);
    job.src_port    = req.src_port;
    job.dst_ip_addr = req.dst_ip_addr;
    job.dst_port    = req.dst_port;
    job.ip_len      = req.payload_bytes + IP_LEN_EXTRA;
    job.udp_len     = req.payload_bytes + UDP_LEN_EXTRA;
    // Sum of the IPv4 header words; the fixed and source address part comes in.
    job.csum_sum    = CSUM_W'(cfg_sum) + CSUM_W'(req.dst_ip_addr[31:16])
                    + CSUM_W'(req.dst_ip_addr[15:0]) + CSUM_W'(job.ip_len);
  end

endmodule

// ===== src/uhb_queue.sv =====
// Two-entry queue of classified jobs between the front and back parts.
module uhb_queue
  import uhb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic valid,
  output job_t head
);

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign valid = count != 2'd0;
  assign head  = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== src/uhb_back.sv =====
// Back part: walks one job through its header words into the output register.
module uhb_back
  import uhb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  job_t        q_job,
  output logic        q_pop,
  input  logic [31:0] local_ip_addr,
  input  logic [47:0] local_mac_addr,
  input  logic [47:0] peer_mac_addr,
  output logic        hdr_valid,
  output hdr_t        hdr,
  input  logic        hdr_stall
);

  logic        busy;
  logic [4:0]  idx;
  job_t        item;
  logic        advance;
  logic        finish;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] csum;
  logic [15:0] word;
  hdr_t        hdr_next;

  // Output register moves when empty or taken.
  assign advance = !hdr_valid || !hdr_stall;
  assign finish  = busy && (item.rejected || idx == LAST_INDEX);
  assign q_pop   = q_valid && (!busy || (advance && finish));

  // Ones'-complement fold of the IPv4 header sum.
  assign fold1 = {1'b0, item.csum_sum[15:0]} + 17'(item.csum_sum[CSUM_W-1:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);
  assign csum  = ~fold2;

  // Header word at the current position.
  always_comb begin
    unique case (idx)
      5'd0:        word = peer_mac_addr[47:32];
      5'd1:        word = peer_mac_addr[31:16];
      5'd2:        word = peer_mac_addr[15:0];
      5'd3:        word = local_mac_addr[47:32];
      5'd4:        word = local_mac_addr[31:16];
      5'd5:        word = local_mac_addr[15:0];
      5'd6:        word = ETH_TYPE_IPV4;
      5'd7:        word = IP_VER_IHL_TOS;
      5'd8:        word = item.ip_len;
      5'd11:       word = IP_TTL_PROTO;
      POS_IP_CSUM: word = csum;
      5'd13:       word = local_ip_addr[31:16];
      5'd14:       word = local_ip_addr[15:0];
      5'd15:       word = item.dst_ip_addr[31:16];
      5'd16:       word = item.dst_ip_addr[15:0];
      5'd17:       word = item.src_port;
      5'd18:       word = item.dst_port;
      5'd19:       word = item.udp_len;
      // Identification, fragment offset and UDP checksum are zero.
      default:     word = 16'h0000;
    endcase
  end

  // A rejected job gives a single marked result.
  always_comb begin
    if (item.rejected) begin
      hdr_next.header_word = 16'h0000;
      hdr_next.word_index  = 5'd0;
      hdr_next.last_word   = 1'b1;
      hdr_next.rejected    = 1'b1;
    end else begin
      hdr_next.header_word = word;
      hdr_next.word_index  = idx;
      hdr_next.last_word   = idx == LAST_INDEX;
      hdr_next.rejected    = 1'b0;
    end
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= 5'd0;
      hdr_valid <= 1'b0;
    end else begin
      if (advance) begin
        hdr_valid <= busy;
      end
      if (q_pop) begin
        busy <= 1'b1;
        idx  <= 5'd0;
      end else if (advance && busy) begin
        if (finish) begin
          busy <= 1'b0;
        end
        idx <= idx + 5'd1;
      end
    end
  end

  // Job and output payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item <= q_job;
    end
    if (advance && busy) begin
      hdr <= hdr_next;
    end
  end

endmodule

// ===== src/udp_ipv4_header_builder_unit.sv =====
// Top level of the UDP/IPv4 header builder: registers, front, queue and back parts.
//
//   Channel  Direction  Word   Handshake
//   req      in         req_t  req_valid / req_stall
//   hdr      out        hdr_t  hdr_valid / hdr_stall
//   apb      in/out     64b    psel / penable / pwrite / pready
//
// A request gives 21 header words, one per cycle while the result side does not
// stall, so the back sequencer and the 16-bit result channel set the sustained
// rate; a rejected request gives one word. A job passes the queue and the job
// register before its first word is in the output register. Reset clears the
// queue and the sequencer; there is no clearing pass. A result-side stall holds
// the output register; the two-entry queue keeps taking requests until it is full.
module udp_ipv4_header_builder_unit
  import uhb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        hdr_valid,
  input  logic        hdr_stall,
  output hdr_t        hdr,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [31:0]           local_ip_addr;
  logic [47:0]           local_mac_addr;
  logic [47:0]           peer_mac_addr;
  logic [1:0]            reg_sel;
  logic                  cfg_write;
  logic [CFG_CSUM_W-1:0] cfg_sum;
  job_t                  front_job;
  job_t                  head_job;
  logic                  q_full;
  logic                  q_valid;
  logic                  q_pop;
  logic                  push;

  // Configuration port.
  assign pready    = 1'b1;
  assign reg_sel   = paddr[4:3];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip_addr  <= LOCAL_IP_RESET;
      local_mac_addr <= LOCAL_MAC_RESET;
      peer_mac_addr  <= PEER_MAC_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_LOCAL_IP:  local_ip_addr  <= pwdata[31:0];
        REG_LOCAL_MAC: local_mac_addr <= pwdata[47:0];
        REG_PEER_MAC:  peer_mac_addr  <= pwdata[47:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_LOCAL_IP:  prdata = 64'(local_ip_addr);
      REG_LOCAL_MAC: prdata = 64'(local_mac_addr);
      REG_PEER_MAC:  prdata = 64'(peer_mac_addr);
      default:       prdata = 64'd0;
    endcase
  end

  // Checksum contribution of the fixed words and the source address.
  assign cfg_sum = CFG_CSUM_W'(IP_VER_IHL_TOS) + CFG_CSUM_W'(IP_TTL_PROTO)
                 + CFG_CSUM_W'(local_ip_addr[31:16]) + CFG_CSUM_W'(local_ip_addr[15:0]);

  // Request side.
  assign req_stall = q_full;
  assign push      = req_valid && !req_stall;

  uhb_front u_front (
    .req     (req),
    .cfg_sum (cfg_sum),
    .job     (front_job)
  );

  uhb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (front_job),
    .pop      (q_pop),
    .full     (q_full),
    .valid    (q_valid),
    .head     (head_job)
  );

  uhb_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_job          (head_job),
    .q_pop          (q_pop),
    .local_ip_addr  (local_ip_addr),
    .local_mac_addr (local_mac_addr),
    .peer_mac_addr  (peer_mac_addr),
    .hdr_valid      (hdr_valid),
    .hdr            (hdr),
    .hdr_stall      (hdr_stall)
  );

  // A rejected result is a lone, empty, final word.
  a_reject_shape: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && hdr.rejected |->
      hdr.last_word && hdr.word_index == 5'd0 && hdr.header_word == 16'h0000)
    else $error("rejected result is not a lone empty word");

  // A header closes at its final position.
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && hdr.last_word && !hdr.rejected |-> hdr.word_index == LAST_INDEX)
    else $error("header closed at the wrong position");

  // Words of one header follow each other without gaps.
  a_word_order: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && !hdr_stall && !hdr.last_word |=>
      hdr_valid && hdr.word_index == $past(hdr.word_index) + 5'd1)
    else $error("header words out of sequence");

endmodule

// ===== tb/sv/header_check_pkg.sv =====
// Header predictor and result scoreboard for the UDP/IPv4 header builder testbench.
package header_check_pkg;
  import uhb_pkg::*;

  class header_checker;
    // Copy of the block's registers as last written.
    logic [31:0] own_ip;
    logic [47:0] own_mac;
    logic [47:0] peer_mac;

    // Header words still owed by the block, oldest first.
    hdr_t expected_words[$];

    int mismatches;
    int words_checked;
    int requests_seen;
    int requests_rejected;

    function new();
      own_ip   = LOCAL_IP_RESET;
      own_mac  = LOCAL_MAC_RESET;
      peer_mac = PEER_MAC_RESET;
    endfunction

    // Values wider than a register are cut to its width.
    function void set_register(logic [1:0] idx, logic [63:0] value);
      case (idx)
        REG_LOCAL_IP:  own_ip   = value[31:0];
        REG_LOCAL_MAC: own_mac  = value[47:0];
        REG_PEER_MAC:  peer_mac = value[47:0];
        default: ;
      endcase
    endfunction

    // Works out the header words for one accepted request and queues them.
    function void add_request(req_t r);
      logic [15:0] words [HDR_WORDS];
      logic [19:0] sum;
      hdr_t w;
      requests_seen++;

      // A frame over the limit gives one rejected word and nothing else.
      if (int'(r.payload_bytes) + HDR_BYTES > MAX_FRAME_BYTES) begin
        requests_rejected++;
        w.header_word = 16'h0000;
        w.word_index  = 5'd0;
        w.last_word   = 1'b1;
        w.rejected    = 1'b1;
        expected_words.push_back(w);
        return;
      end

      // Ethernet header.
      words[0] = peer_mac[47:32];
      words[1] = peer_mac[31:16];
      words[2] = peer_mac[15:0];
      words[3] = own_mac[47:32];
      words[4] = own_mac[31:16];
      words[5] = own_mac[15:0];
      words[6] = 16'h0800;
      // IPv4 header, checksum left at zero while it is summed.
      words[7]  = 16'h4500;
      words[8]  = r.payload_bytes + 16'd28;
      words[9]  = 16'h0000;
      words[10] = 16'h0000;
      words[11] = {8'd100, 8'd17};
      words[12] = 16'h0000;
      words[13] = own_ip[31:16];
      words[14] = own_ip[15:0];
      words[15] = r.dst_ip_addr[31:16];
      words[16] = r.dst_ip_addr[15:0];
      // UDP header with a zero checksum.
      words[17] = r.src_port;
      words[18] = r.dst_port;
      words[19] = r.payload_bytes + 16'd8;
      words[20] = 16'h0000;

      // Ones'-complement sum over the ten IPv4 words, carries folded back twice.
      sum = '0;
      for (int i = 7; i <= 16; i++) sum = sum + words[i];
      sum = sum[15:0] + sum[19:16];
      sum = sum + sum[19:16];
      words[12] = ~sum[15:0];

      for (int k = 0; k < HDR_WORDS; k++) begin
        w.header_word = words[k];
        w.word_index  = 5'(k);
        w.last_word   = (k == HDR_WORDS - 1);
        w.rejected    = 1'b0;
        expected_words.push_back(w);
      end
    endfunction

    // Compares one accepted word with the oldest expected one.
    function void check_word(hdr_t got);
      hdr_t want;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected word: word=%h index=%0d last=%b rejected=%b",
                   got.header_word, got.word_index, got.last_word, got.rejected);
        return;
      end
      want = expected_words.pop_front();
      words_checked++;
      if (got.header_word !== want.header_word || got.word_index !== want.word_index ||
          got.last_word !== want.last_word || got.rejected !== want.rejected) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch (word/index/last/rejected): expected %h/%0d/%b/%b, got %h/%0d/%b/%b",
                   want.header_word, want.word_index, want.last_word, want.rejected,
                   got.header_word, got.word_index, got.last_word, got.rejected);
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/udp_ipv4_header_builder_unit_test.sv =====
// Testbench for the UDP/IPv4 header builder: random and directed requests checked word by word.
module udp_ipv4_header_builder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import uhb_pkg::*;
  import header_check_pkg::*;

  localparam int WATCHDOG_CYCLES  = 4000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 8;
  localparam logic [15:0] MAX_ACCEPTED = 16'(MAX_FRAME_BYTES - HDR_BYTES);

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req = '0;
  logic        hdr_valid;
  logic        hdr_stall = 1'b0;
  hdr_t        hdr;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  header_checker sb;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int settings_used = 1;

  udp_ipv4_header_builder_unit DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .hdr_valid(hdr_valid), .hdr_stall(hdr_stall), .hdr(hdr),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Result side: check each accepted word, then decide whether to stall the next one.
  always @(posedge clk) begin
    if (rst) begin
      hdr_stall <= 1'b0;
    end else begin
      if (hdr_valid && !hdr_stall) sb.check_word(hdr);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        hdr_stall <= 1'b1;
      end else begin
        hdr_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // The run ends with a failure if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (hdr_valid && !hdr_stall) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic req_t make_request(logic [15:0] sport, logic [31:0] dip,
                                        logic [15:0] dport, logic [15:0] plen);
    req_t r;
    r.src_port = sport;
    r.dst_ip_addr = dip;
    r.dst_port = dport;
    r.payload_bytes = plen;
    return r;
  endfunction

  // Mostly frames that fit, some right at the limit, some far beyond it.
  function automatic req_t random_request();
    req_t r;
    r.src_port = 16'($urandom);
    r.dst_ip_addr = $urandom;
    r.dst_port = 16'($urandom);
    case ($urandom_range(9))
      0: r.payload_bytes = 16'($urandom_range(65535, MAX_FRAME_BYTES - HDR_BYTES + 1));
      1: r.payload_bytes = 16'($urandom_range(MAX_FRAME_BYTES - HDR_BYTES + 4,
                                              MAX_FRAME_BYTES - HDR_BYTES - 3));
      2: r.payload_bytes = 16'($urandom_range(3));
      default: r.payload_bytes = 16'($urandom_range(MAX_FRAME_BYTES - HDR_BYTES));
    endcase
    return r;
  endfunction

  // Offers one request word after a random gap and waits until it is taken.
  task automatic send_request(input req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.add_request(r);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_request(random_request());
  endtask

  // Stops offering and waits for every owed word, plus the pipeline latency.
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the write lands when pready is seen high.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_register(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [63:0] ip, input logic [63:0] mac,
                           input logic [63:0] peer);
    write_reg(REG_LOCAL_IP, ip);
    write_reg(REG_LOCAL_MAC, mac);
    write_reg(REG_PEER_MAC, peer);
    settings_used++;
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests under the reset register values.
    send_request(make_request(16'h0000, 32'h0000_0000, 16'h0000, 16'h0000));
    send_request(make_request(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, MAX_ACCEPTED));
    send_request(make_request(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, MAX_ACCEPTED + 16'd1));
    send_request(make_request(16'h0000, 32'h0000_0000, 16'h0000, 16'hFFFF));
    send_request(make_request(16'hA5A5, 32'h5A5A_5A5A, 16'hA5A5, 16'h0001));
    send_request(make_request(16'h5A5A, 32'hA5A5_A5A5, 16'h5A5A, 16'h0800));
    send_request(make_request(16'h1234, 32'hC0A8_0001, 16'h0035, 16'd512));
    send_request(make_request(16'h8000, 32'h8000_0001, 16'h0001, MAX_ACCEPTED + 16'd1));
    send_request(make_request(16'h0001, 32'h0000_FFFF, 16'h8000, 16'h0000));
    wait_drained();

    // All registers at zero; the sender idles a little, the receiver a lot.
    write_all(64'h0, 64'h0, 64'h0);
    tx_idle_pct = 18;
    rx_idle_pct = 59;
    send_random(110);
    wait_drained();

    // All registers at their maximum, with extra upper bits that must be dropped.
    write_all({64{1'b1}}, {64{1'b1}}, {64{1'b1}});
    tx_idle_pct = 59;
    rx_idle_pct = 18;
    send_request(make_request(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, MAX_ACCEPTED));
    send_request(make_request(16'h0000, 32'h0000_0000, 16'h0000, 16'h0000));
    send_random(55);
    // The sender pauses until every owed word has come out.
    wait_drained();
    send_random(55);
    wait_drained();

    // Random register values, no idling, and one long receiver hold-off at the start.
    write_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_requests++;
    send_random(100);
    wait_drained();

    $display("Run covered %0d requests (%0d over the frame limit) under %0d register settings.",
             sb.requests_seen, sb.requests_rejected, settings_used);
    $display("Header words checked: %0d, mismatches: %0d.", sb.words_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== udp_ipv4_header_builder_unit.f =====
src/uhb_pkg.sv
src/uhb_front.sv
src/uhb_queue.sv
src/uhb_back.sv
src/udp_ipv4_header_builder_unit.sv
tb/sv/header_check_pkg.sv
tb/sv/udp_ipv4_header_builder_unit_test.sv
